### rtl/core/chunk_adler32_framer_assert.svh
// Assertion macros shared by the checking logic of the chunk Adler-32 framer.
`ifndef CHUNK_ADLER32_FRAMER_ASSERT_SVH
`define CHUNK_ADLER32_FRAMER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define CAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define CAF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/caf_pkg.sv
// Package with the types, constants and helper functions of the chunk Adler-32 framer.
`default_nettype none

package caf_pkg;

  // Chunk geometry and checksum modulus.
  localparam int          CHUNK_BYTES = 65536;
  localparam int          CNT_W       = $clog2(CHUNK_BYTES + 1);
  localparam logic [15:0] ADLER_MOD   = 16'd65521;
  localparam logic [31:0] OFFSET_STEP = 32'(CHUNK_BYTES + 4);
  localparam logic [15:0] CFG_RESET   = 16'd76;

  // Padding product and its folding widths (2^16 is congruent to 15).
  localparam int PROD_W  = CNT_W + 16;
  localparam int FOLD_W  = ((PROD_W - 12) > 16 ? (PROD_W - 12) : 16) + 1;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    ITEM_DATA  = 1'b0,
    ITEM_FLUSH = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data_byte;
  } item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_FOLD,
    ST_FIN
  } back_state_e;

  // One conditional subtraction brings a value below twice the modulus into range.
  function automatic logic [15:0] mod_once(input logic [16:0] value);
    logic [16:0] diff;
    diff = value - {1'b0, ADLER_MOD};
    mod_once = (value >= {1'b0, ADLER_MOD}) ? diff[15:0] : value[15:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/caf_ifs.sv
// Stream and configuration interfaces of the chunk Adler-32 framer.
`default_nettype none

// Input stream: one command with its data byte per transaction.
interface caf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

// Result stream: one chunk table entry per transaction.
interface caf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] chunk_index;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_checksum;
  modport source (output valid, output chunk_index, output chunk_offset,
                  output chunk_checksum, input ready);
  modport sink (input valid, input chunk_index, input chunk_offset,
                input chunk_checksum, output ready);
endinterface

// Configuration write channel for the first chunk offset.
interface caf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_chunk_offset;
  modport source (output valid, output first_chunk_offset, input ready);
  modport sink (input valid, input first_chunk_offset, output ready);
endinterface

`default_nettype wire

### rtl/core/chunk_adler32_framer.sv
// Top level of the chunk Adler-32 framer.
//
// Usage: bytes arrive on in_i (command 0 = data byte, command 1 = flush); each
// full chunk of CHUNK_BYTES bytes, or each flushed partial chunk, yields one
// table entry on out_o with the chunk index, its offset and its Adler-32 sum.
// A flush on an empty chunk yields nothing. cfg_i sets the first chunk offset
// and is always ready; it moves the offset only before the first entry.
// Throughput: one data byte per cycle while the back end is in its run state
// and, for a byte that closes a chunk, the result register is free. After
// taking a flush the back end takes nothing until it has passed its multiply,
// fold and final reduction steps and loaded the entry. With the queue empty,
// a closing data byte passes the two-entry queue and the result register; a
// flush passes the queue, those three steps and the result register.
// Reset clears the sums to their start values, the chunk count to zero and the
// offset to 76; nothing is pending afterwards.
// When the receiver stalls, the entry holds on out_o; the back end stops at the
// next chunk close and the queue fills, after which in_i.ready falls.
`default_nettype none

module chunk_adler32_framer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  caf_cfg_if.sink   cfg_i,
  caf_in_if.sink    in_i,
  caf_out_if.source out_o
);
  import caf_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_ready;

  caf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  caf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .cfg_i        (cfg_i),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

### rtl/core/caf_front.sv
// Front end: accepts stream transactions, classifies them and queues them for the back end.
`default_nettype none

module caf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  caf_in_if.sink             in_i,
  output caf_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  wire logic          item_ready_i
);
  import caf_pkg::*;

  item_t                 entries_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic                  push, pop;
  item_t                 item_in;

  // Classify the incoming transaction.
  always_comb begin
    item_in.kind      = item_kind_e'(in_i.command);
    item_in.data_byte = in_i.data_byte;
  end

  assign in_i.ready   = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = entries_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/caf_back.sv
// Back end: runs the Adler-32 sums, closes chunks and holds the result register.
`default_nettype none

module caf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire caf_pkg::item_t item_i,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  caf_cfg_if.sink            cfg_i,
  caf_out_if.source          out_o
);
  import caf_pkg::*;

  back_state_e        state_q, state_d;
  logic [15:0]        sum_low_q, sum_low_d;
  logic [15:0]        sum_high_q, sum_high_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [31:0]        chunks_q, chunks_d;
  logic [31:0]        next_off_q, next_off_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [FOLD_W-1:0]  fold_q, fold_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_index_q, out_index_d;
  logic [31:0]        out_offset_q, out_offset_d;
  logic [31:0]        out_sum_q, out_sum_d;

  logic               out_free, pop, emit;
  logic [15:0]        emit_low, emit_high;
  logic [15:0]        low_new, high_new, pad_term, flush_high;
  logic [CNT_W-1:0]   count_inc, pad;
  logic [16:0]        fold2;

  assign cfg_i.ready  = 1'b1;
  assign out_free     = !out_valid_q || out_o.ready;
  // Only a data byte that closes a chunk has to wait for the result register;
  // a flush waits for it in its final step.
  assign item_ready_o = (state_q == ST_RUN) &&
                        (out_free || (item_i.kind == ITEM_FLUSH) ||
                         (count_inc != CNT_W'(CHUNK_BYTES)));
  assign pop          = item_valid_i && item_ready_o;

  // Per-byte sums.
  assign low_new   = mod_once({1'b0, sum_low_q} + {9'b0, item_i.data_byte});
  assign high_new  = mod_once({1'b0, sum_high_q} + {1'b0, low_new});
  assign count_inc = count_q + 1'b1;

  // Padding contribution: pad times sum_low, folded down modulo 65521.
  assign pad        = CNT_W'(CHUNK_BYTES) - count_q;
  assign fold2      = 17'(fold_q[FOLD_W-1:16]) * 17'd15 + {1'b0, fold_q[15:0]};
  assign pad_term   = mod_once(fold2);
  assign flush_high = mod_once({1'b0, sum_high_q} + {1'b0, pad_term});

  // Sequencer and state update.
  always_comb begin
    state_d      = state_q;
    sum_low_d    = sum_low_q;
    sum_high_d   = sum_high_q;
    count_d      = count_q;
    chunks_d     = chunks_q;
    next_off_d   = next_off_q;
    prod_d       = prod_q;
    fold_d       = fold_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_index_d  = out_index_q;
    out_offset_d = out_offset_q;
    out_sum_d    = out_sum_q;
    emit         = 1'b0;
    emit_low     = sum_low_q;
    emit_high    = sum_high_q;

    // The offset follows the register until the first chunk is out.
    if (cfg_i.valid && (chunks_q == '0)) begin
      next_off_d = {16'b0, cfg_i.first_chunk_offset};
    end

    case (state_q)
      ST_RUN: begin
        if (pop) begin
          if (item_i.kind == ITEM_DATA) begin
            sum_low_d  = low_new;
            sum_high_d = high_new;
            count_d    = count_inc;
            if (count_inc == CNT_W'(CHUNK_BYTES)) begin
              emit      = 1'b1;
              emit_low  = low_new;
              emit_high = high_new;
            end
          end else if (count_q != '0) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(pad) * PROD_W'(sum_low_q);
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        fold_d  = FOLD_W'(prod_q[PROD_W-1:16]) * FOLD_W'(15) + FOLD_W'(prod_q[15:0]);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_high = flush_high;
          state_d   = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    // Close the chunk: load the table entry and restart the sums.
    if (emit) begin
      out_valid_d  = 1'b1;
      out_index_d  = chunks_q;
      out_offset_d = next_off_q;
      out_sum_d    = {emit_high, emit_low};
      sum_low_d    = 16'd1;
      sum_high_d   = '0;
      count_d      = '0;
      chunks_d     = chunks_q + 32'd1;
      next_off_d   = next_off_q + OFFSET_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      sum_low_q   <= 16'd1;
      sum_high_q  <= '0;
      count_q     <= '0;
      chunks_q    <= '0;
      next_off_q  <= {16'b0, CFG_RESET};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_low_q   <= sum_low_d;
      sum_high_q  <= sum_high_d;
      count_q     <= count_d;
      chunks_q    <= chunks_d;
      next_off_q  <= next_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    fold_q       <= fold_d;
    out_index_q  <= out_index_d;
    out_offset_q <= out_offset_d;
    out_sum_q    <= out_sum_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.chunk_index    = out_index_q;
  assign out_o.chunk_offset   = out_offset_q;
  assign out_o.chunk_checksum = out_sum_q;

endmodule

`default_nettype wire

### rtl/core/caf_checker.sv
// Port-level checker of the chunk Adler-32 framer and its bind.
`default_nettype none
`include "chunk_adler32_framer_assert.svh"

module caf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_index_i,
  input wire logic [31:0] out_offset_i,
  input wire logic [31:0] out_checksum_i
);
  import caf_pkg::*;

  logic        seen_q;
  logic [31:0] last_index_q;
  logic [31:0] last_offset_q;
  logic        out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  // Remember the last entry handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_index_q  <= '0;
      last_offset_q <= '0;
    end else if (out_acc) begin
      seen_q        <= 1'b1;
      last_index_q  <= out_index_i;
      last_offset_q <= out_offset_i;
    end
  end

  `CAF_ASSERT_ALWAYS(a_no_entry_in_reset, !rst_ni |=> !out_valid_i, "entry valid during reset")

  `CAF_ASSERT(a_entry_held, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_index_i) && $stable(out_checksum_i)), "stalled entry changed")

  `CAF_ASSERT(a_sums_reduced, out_valid_i |-> ((out_checksum_i[15:0] < ADLER_MOD) && (out_checksum_i[31:16] < ADLER_MOD)), "checksum half not reduced")

  `CAF_ASSERT(a_index_step, (out_acc && seen_q) |-> (out_index_i == last_index_q + 32'd1), "chunk index skipped")

  `CAF_ASSERT(a_offset_step, (out_acc && seen_q) |-> (out_offset_i == last_offset_q + OFFSET_STEP), "chunk offset step wrong")

endmodule

bind chunk_adler32_framer caf_checker u_caf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_index_i    (out_o.chunk_index),
  .out_offset_i   (out_o.chunk_offset),
  .out_checksum_i (out_o.chunk_checksum)
);

`default_nettype wire
